>>> sv/dtsi_pkg.sv
`timescale 1ns / 1ps

package dtsi_pkg;

  // Field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned ScaleW = 5;
  localparam int unsigned FracW  = 5;
  localparam int unsigned MagW   = 64;
  localparam int unsigned DigitW = 4;

  // Character codes
  localparam logic [CharW-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

  // Fraction count saturates here
  localparam logic [FracW-1:0] FRAC_SAT = 5'd19;

  // Magnitude limits: 2^63 for negative values, 2^63-1 for positive ones
  localparam logic [MagW-1:0] MAG_CAP     = 64'h8000_0000_0000_0000;
  localparam logic [MagW-1:0] MAG_CAP_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DECIMALS = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_SCALE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  // Request to the shared times-ten unit
  typedef struct packed {
    logic [MagW-1:0]   mag;
    logic [DigitW-1:0] addend;
    logic [MagW-1:0]   cap;
  } mul10_req_t;

  // Response of the shared times-ten unit
  typedef struct packed {
    logic [MagW-1:0] prod;
    logic            ovf;
  } mul10_rsp_t;

endpackage

>>> sv/decimal_text_to_scaled_int.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata               tuser        tlast
// s_axis    in         [7:0] char_code     [0] has_char is_last
// m_axis    out        [63:0] fixed_val    [1:0] status -
// cfg       in         [4:0] scale (written when cfg_we_i is high)
//
// A character without the last mark leaves the sequencer in S_IDLE, ready for
// the next one. After a last item, S_EVAL checks the text; the final scaling runs through the
// shared times-ten unit once per missing decimal place (at most MAX_SCALE times);
// an error found before scaling goes from S_EVAL straight to S_EMIT.
// s_axis_tready_o is low from the last item until its result is loaded into
// the output register; the result waits there while m_axis_tready_i is low.
// rst_ni clears the sequencer, the text state, the scale and the output valid.

module decimal_text_to_scaled_int #(
  parameter int unsigned MAX_SCALE = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [dtsi_pkg::ScaleW-1:0]   cfg_wdata_i,      // scale
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dtsi_pkg::CharW-1:0]    s_axis_tdata_i,   // [7:0] char_code
  input  logic                          s_axis_tuser_i,   // [0] has_char
  input  logic                          s_axis_tlast_i,   // is_last
  // output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [dtsi_pkg::MagW-1:0]     m_axis_tdata_o,   // [63:0] fixed_val
  output logic [1:0]                    m_axis_tuser_o    // [1:0] status
);
  import dtsi_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SCALE + 2);

  state_e            state_q, state_d;
  logic [ScaleW-1:0] scale_q;
  logic [MagW-1:0]   mag_q, mag_d;
  logic              neg_q, neg_d;
  logic              kept_q, kept_d;
  logic              dot_q, dot_d;
  logic              mant_end_q, mant_end_d;
  logic              digit_q, digit_d;
  logic [FracW-1:0]  frac_q, frac_d;
  logic              ovf_q, ovf_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  status_e           status_q, status_d;

  logic              out_valid_q;
  logic [MagW-1:0]   out_data_q;
  status_e           out_status_q;

  mul10_req_t        unit_req;
  mul10_rsp_t        unit_rsp;

  logic              in_acc;
  logic              out_free;
  logic [ScaleW-1:0] scale_eff;
  logic              is_digit, is_dot, is_minus;
  logic              push_en;
  logic [DigitW-1:0] push_digit;
  logic [CharW-1:0]  digit_off;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Scale clamped to the supported maximum
  assign scale_eff = (scale_q > ScaleW'(MAX_SCALE)) ? ScaleW'(MAX_SCALE) : scale_q;

  // Character classes
  assign is_digit  = (s_axis_tdata_i >= CHAR_ZERO) && (s_axis_tdata_i <= CHAR_NINE);
  assign is_dot    = (s_axis_tdata_i == CHAR_DOT);
  assign is_minus  = (s_axis_tdata_i == CHAR_MINUS) && !kept_q;
  assign digit_off = s_axis_tdata_i - CHAR_ZERO;

  // Digit to add: the character's value in the mantissa, zero for padding
  assign push_digit = (is_digit && !mant_end_q) ? digit_off[DigitW-1:0] : '0;

  // Shared unit operands
  always_comb begin
    unit_req.mag    = mag_q;
    unit_req.addend = (state_q == S_SCALE) ? '0 : push_digit;
    unit_req.cap    = ((state_q == S_SCALE) && !neg_q) ? MAG_CAP_POS : MAG_CAP;
  end

  dtsi_mul10 u_mul10 (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  // Sequencer and text state
  always_comb begin
    state_d    = state_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    kept_d     = kept_q;
    dot_d      = dot_q;
    mant_end_d = mant_end_q;
    digit_d    = digit_q;
    frac_d     = frac_q;
    ovf_d      = ovf_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    push_en    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i) begin
            if (is_minus) begin
              kept_d = 1'b1;
              neg_d  = 1'b1;
            end else if (is_digit || is_dot) begin
              kept_d = 1'b1;
              if (dot_q && (frac_q < FRAC_SAT)) begin
                frac_d = frac_q + 1'b1;
              end
              if (is_dot) begin
                if (!dot_q) begin
                  dot_d = 1'b1;
                end else begin
                  mant_end_d = 1'b1;
                  push_en    = 1'b1;
                end
              end else if (mant_end_q) begin
                push_en = 1'b1;
              end else begin
                digit_d    = 1'b1;
                push_en    = 1'b1;
              end
            end
          end
          // Accumulate a digit unless already overflowed
          if (push_en && !ovf_q) begin
            if (unit_rsp.ovf) begin
              ovf_d = 1'b1;
            end else begin
              mag_d = unit_rsp.prod;
            end
          end
          if (s_axis_tlast_i) begin
            state_d = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        cnt_d = CntW'(scale_eff - frac_q);
        priority if (!kept_q) begin
          status_d = ST_INVALID;
          state_d  = S_EMIT;
        end else if (frac_q > scale_eff) begin
          status_d = ST_DECIMALS;
          state_d  = S_EMIT;
        end else if (!digit_q) begin
          status_d = ST_INVALID;
          state_d  = S_EMIT;
        end else if (ovf_q) begin
          status_d = ST_OVERFLOW;
          state_d  = S_EMIT;
        end else begin
          state_d = S_SCALE;
        end
      end

      S_SCALE: begin
        if (cnt_q == '0) begin
          status_d = (mag_q > unit_req.cap) ? ST_OVERFLOW : ST_OK;
          state_d  = S_EMIT;
        end else if (unit_rsp.ovf) begin
          status_d = ST_OVERFLOW;
          state_d  = S_EMIT;
        end else begin
          mag_d = unit_rsp.prod;
          cnt_d = cnt_q - 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          mag_d      = '0;
          neg_d      = 1'b0;
          kept_d     = 1'b0;
          dot_d      = 1'b0;
          mant_end_d = 1'b0;
          digit_d    = 1'b0;
          frac_d     = '0;
          ovf_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and text state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scale_q    <= '0;
      mag_q      <= '0;
      neg_q      <= 1'b0;
      kept_q     <= 1'b0;
      dot_q      <= 1'b0;
      mant_end_q <= 1'b0;
      digit_q    <= 1'b0;
      frac_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      mag_q      <= mag_d;
      neg_q      <= neg_d;
      kept_q     <= kept_d;
      dot_q      <= dot_d;
      mant_end_q <= mant_end_d;
      digit_q    <= digit_d;
      frac_q     <= frac_d;
      ovf_q      <= ovf_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  // Step count and status, no reset needed
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    status_q <= status_d;
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: signed result, zero on any error
  always_ff @(posedge clk_i) begin
    if ((state_q == S_EMIT) && out_free) begin
      out_status_q <= status_q;
      if (status_q != ST_OK) begin
        out_data_q <= '0;
      end else if (neg_q) begin
        out_data_q <= '0 - mag_q;
      end else begin
        out_data_q <= mag_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

>>> sv/dtsi_mul10.sv
`timescale 1ns / 1ps

// Shared unit: mag * 10 + addend, flags a result above cap.
module dtsi_mul10 (
  input  dtsi_pkg::mul10_req_t req_i,
  output dtsi_pkg::mul10_rsp_t rsp_o
);
  import dtsi_pkg::*;

  localparam int unsigned SumW = MagW + 4;

  logic [SumW-1:0] sum;

  // 10*m = 8*m + 2*m, four guard bits keep the full product
  always_comb begin
    sum = ({{4{1'b0}}, req_i.mag} << 3) + ({{4{1'b0}}, req_i.mag} << 1)
        + {{(SumW-DigitW){1'b0}}, req_i.addend};
    rsp_o.prod = sum[MagW-1:0];
    rsp_o.ovf  = sum > {{4{1'b0}}, req_i.cap};
  end

endmodule
